FILE: sv/nls_pkg.sv
// Package for the numeric literal scanner: beat structs, status codes,
// kind bits, register map and value range. No dependencies.
package nls_pkg;

    // Width of the running magnitude; the signed value range is VALUE_WIDTH bits
    localparam int VALUE_WIDTH = 64;

    // Fixed width of the delivered integer value
    localparam int INT_W = 64;

    // APB register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_ACCEPTED_KINDS = 1'b0;

    // Kind bits of accepted_kinds, kinds_left and kind_read
    localparam int KIND_FLOAT_BIT = 0;
    localparam int KIND_INT_BIT = 1;
    localparam logic [1:0] KIND_FLOAT = 2'b01;
    localparam logic [1:0] KIND_INT = 2'b10;
    localparam logic [1:0] KIND_BOTH = 2'b11;
    localparam logic [1:0] KIND_NONE = 2'b00;

    // Largest magnitude a negative literal may reach: 2^(VALUE_WIDTH-1)
    localparam logic [VALUE_WIDTH-1:0] MAG_LIMIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // Token end status
    typedef enum logic [2:0] {
        ST_INT_OK      = 3'd0,
        ST_FLOAT_OK    = 3'd1,
        ST_KIND        = 3'd2,
        ST_NO_MANTISSA = 3'd3,
        ST_MALFORMED   = 3'd4,
        ST_RANGE       = 3'd5
    } status_t;

    // Input beat: one peeked character or end of stream
    typedef struct packed {
        logic [7:0] ch;
        logic       at_end;
    } char_beat_t;

    // Result beat: one per input beat
    typedef struct packed {
        logic                    consumed;
        logic                    done_res;
        status_t                 status;
        logic signed [INT_W-1:0] int_value;
    } res_beat_t;

endpackage

FILE: sv/numeric_literal_scanner.sv
// Numeric literal scanner top level: character decode, token state and
// result register, plus the APB configuration register. Uses nls_pkg.
//
// The scanner answers each character beat with one result beat in the next
// cycle and sustains one character per cycle unless res_ready stalls. The
// figure is set by the token state update (flags plus one multiply by the
// radix, done as shifts and adds, and a compare against 2^(VALUE_WIDTH-1)),
// which completes in the cycle the character is accepted and lands in the
// result register. char_ready is high whenever the result register is empty
// or being drained the same cycle. A result with done_res set does not
// consume its character: the source presents it again as the first
// character of the next token. Write accepted_kinds only while idle; the
// new value applies from the next token.
module numeric_literal_scanner (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nls_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [nls_pkg::APB_DATA_W-1:0] pwdata,
    output logic [nls_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    // character channel
    input  logic                           char_valid,
    output logic                           char_ready,
    input  nls_pkg::char_beat_t            char_beat,
    // result channel
    output logic                           res_valid,
    input  logic                           res_ready,
    output nls_pkg::res_beat_t             res_beat
);
    import nls_pkg::*;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_BIN = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_HEX = 2'd3
    } radix_t;

    localparam int PROD_W = VALUE_WIDTH + 5;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_B  = 8'h42;
    localparam logic [7:0] CH_UC_E  = 8'h45;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_UC_O  = 8'h4F;
    localparam logic [7:0] CH_UC_P  = 8'h50;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_E  = 8'h65;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_O  = 8'h6F;
    localparam logic [7:0] CH_LC_P  = 8'h70;
    localparam logic [7:0] CH_LC_X  = 8'h78;

    // configuration
    logic [1:0] accepted_kinds_reg;
    logic       cfg_write;

    // token state
    logic                   seen_mantissa_reg, seen_mantissa_next;
    logic                   seen_exponent_reg, seen_exponent_next;
    logic                   seen_sign_reg, seen_sign_next;
    logic                   seen_point_reg, seen_point_next;
    logic                   exp_digit_seen_reg, exp_digit_seen_next;
    logic [1:0]             kinds_left_reg, kinds_left_next;
    logic [1:0]             kind_read_reg, kind_read_next;
    radix_t                 radix_reg, radix_next;
    logic [1:0]             text_length_reg, text_length_next;
    logic                   leads_with_sign_reg, leads_with_sign_next;
    logic                   negative_reg, negative_next;
    logic                   last_was_zero_reg, last_was_zero_next;
    logic                   last_was_exp_reg, last_was_exp_next;
    logic [VALUE_WIDTH-1:0] magnitude_reg, magnitude_next;
    logic                   overflow_reg, overflow_next;

    // result register
    logic      res_valid_reg, res_valid_next;
    res_beat_t res_beat_reg, res_beat_next;

    // step decode
    logic              accept;
    logic [7:0]        ch;
    logic              is_dec, is_hex_letter, is_sign;
    logic [3:0]        dig;
    logic              prefix_ok;
    logic              take, keep, take_dig, finish;
    logic [7:0]        kept_ch;
    logic [PROD_W-1:0] mag_ext, scaled, cand;
    logic              digit_fits;
    logic [1:0]        kinds;
    status_t           fin_status;
    logic [INT_W-1:0]  fin_value;

    // APB register: always ready, one register at index zero
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_ACCEPTED_KINDS)
        begin
            prdata = {{(APB_DATA_W-2){1'b0}}, accepted_kinds_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_kinds_reg <= KIND_BOTH;
        end
        else if (cfg_write && (paddr[APB_ADDR_W-1:2] == REG_ACCEPTED_KINDS))
        begin
            accepted_kinds_reg <= pwdata[1:0];
        end
    end

    // handshake: the result register decouples the two sides
    assign char_ready = !res_valid_reg || res_ready;
    assign accept     = char_valid && char_ready;
    assign res_valid  = res_valid_reg;
    assign res_beat   = res_beat_reg;

    // character classes
    assign ch            = char_beat.ch;
    assign is_dec        = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_hex_letter = ((ch >= CH_LC_A) && (ch <= CH_LC_F)) ||
                           ((ch >= CH_UC_A) && (ch <= CH_UC_F));
    assign is_sign       = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign dig           = is_dec ? ch[3:0] : 4'(ch[3:0] + 4'd9);

    // prefix letter allowed only right after a leading zero
    assign prefix_ok = (radix_reg == RADIX_DEC) && last_was_zero_reg &&
                       ((text_length_reg == 2'd1) ||
                        ((text_length_reg == 2'd2) && leads_with_sign_reg));

    // magnitude * radix + digit, as shifts and adds
    assign mag_ext = PROD_W'(magnitude_reg);

    always_comb
    begin
        case (radix_reg)
            RADIX_DEC: scaled = (mag_ext << 3) + (mag_ext << 1);
            RADIX_BIN: scaled = mag_ext << 1;
            RADIX_OCT: scaled = mag_ext << 3;
            RADIX_HEX: scaled = mag_ext << 4;
            default:   scaled = '0;
        endcase
    end

    assign cand = scaled + PROD_W'(dig);

    always_comb
    begin
        case (radix_reg)
            RADIX_BIN: digit_fits = (dig < 4'd2);
            RADIX_OCT: digit_fits = (dig < 4'd8);
            default:   digit_fits = 1'b1;
        endcase
    end

    // token end status from the state before this beat
    assign kinds = kind_read_reg & kinds_left_reg;

    always_comb
    begin
        fin_value = '0;
        if (kinds == KIND_NONE)
        begin
            fin_status = ST_KIND;
        end
        else if (!seen_mantissa_reg)
        begin
            fin_status = ST_NO_MANTISSA;
        end
        else if (seen_exponent_reg && !exp_digit_seen_reg)
        begin
            fin_status = ST_MALFORMED;
        end
        else if (!kinds[KIND_INT_BIT])
        begin
            fin_status = ST_FLOAT_OK;
        end
        else if (overflow_reg || (!negative_reg && magnitude_reg[VALUE_WIDTH-1]))
        begin
            fin_status = ST_RANGE;
        end
        else
        begin
            fin_status = ST_INT_OK;
            fin_value  = negative_reg ? INT_W'(0) - INT_W'(magnitude_reg)
                                      : INT_W'(magnitude_reg);
        end
    end

    // next token state and result beat
    always_comb
    begin
        seen_mantissa_next   = seen_mantissa_reg;
        seen_exponent_next   = seen_exponent_reg;
        seen_sign_next       = seen_sign_reg;
        seen_point_next      = seen_point_reg;
        exp_digit_seen_next  = exp_digit_seen_reg;
        kinds_left_next      = kinds_left_reg;
        kind_read_next       = kind_read_reg;
        radix_next           = radix_reg;
        text_length_next     = text_length_reg;
        leads_with_sign_next = leads_with_sign_reg;
        negative_next        = negative_reg;
        last_was_zero_next   = last_was_zero_reg;
        last_was_exp_next    = last_was_exp_reg;
        magnitude_next       = magnitude_reg;
        overflow_next        = overflow_reg;
        take                 = 1'b0;
        keep                 = 1'b0;
        take_dig             = 1'b0;
        kept_ch              = ch;

        // classify the character
        if (!char_beat.at_end)
        begin
            if (ch == CH_DOT)
            begin
                if (!seen_point_reg && !seen_exponent_reg && kinds_left_reg[KIND_FLOAT_BIT])
                begin
                    keep            = 1'b1;
                    seen_point_next = 1'b1;
                    kind_read_next  = KIND_FLOAT;
                    take            = 1'b1;
                end
            end
            else if (is_sign)
            begin
                if ((text_length_reg == 2'd0) ||
                    (kinds_left_reg[KIND_FLOAT_BIT] && seen_exponent_reg && last_was_exp_reg))
                begin
                    if (text_length_reg == 2'd0)
                    begin
                        negative_next = (ch == CH_MINUS);
                    end
                    keep           = 1'b1;
                    seen_sign_next = 1'b1;
                    take           = 1'b1;
                end
            end
            else if ((ch == CH_LC_X) || (ch == CH_UC_X))
            begin
                if (prefix_ok)
                begin
                    keep               = 1'b1;
                    kept_ch            = CH_LC_X;
                    seen_mantissa_next = 1'b0;
                    radix_next         = RADIX_HEX;
                    take               = 1'b1;
                end
            end
            else if ((ch == CH_LC_O) || (ch == CH_UC_O))
            begin
                if (kinds_left_reg[KIND_INT_BIT] && prefix_ok)
                begin
                    seen_mantissa_next = 1'b0;
                    radix_next         = RADIX_OCT;
                    kind_read_next     = KIND_INT;
                    kinds_left_next    = kinds_left_reg & KIND_INT;
                    take               = 1'b1;
                end
            end
            else if ((ch == CH_LC_P) || (ch == CH_UC_P))
            begin
                if (kinds_left_reg[KIND_FLOAT_BIT] && !seen_exponent_reg &&
                    (radix_reg == RADIX_HEX))
                begin
                    keep               = 1'b1;
                    kept_ch            = CH_LC_P;
                    seen_exponent_next = 1'b1;
                    kind_read_next     = KIND_FLOAT;
                    take               = 1'b1;
                end
            end
            else if (((ch == CH_LC_E) || (ch == CH_UC_E)) && (radix_reg != RADIX_HEX))
            begin
                if ((radix_reg == RADIX_DEC) && !seen_exponent_reg && seen_mantissa_reg &&
                    kinds_left_reg[KIND_FLOAT_BIT])
                begin
                    keep               = 1'b1;
                    kept_ch            = CH_LC_E;
                    seen_exponent_next = 1'b1;
                    kind_read_next     = KIND_FLOAT;
                    take               = 1'b1;
                end
            end
            else if (((ch == CH_LC_B) || (ch == CH_UC_B)) && kinds_left_reg[KIND_INT_BIT] &&
                     prefix_ok)
            begin
                seen_mantissa_next = 1'b0;
                radix_next         = RADIX_BIN;
                kind_read_next     = KIND_INT;
                kinds_left_next    = kinds_left_reg & KIND_INT;
                take               = 1'b1;
            end
            else if (is_dec)
            begin
                if (digit_fits)
                begin
                    take_dig = 1'b1;
                end
            end
            else if (is_hex_letter)
            begin
                if ((radix_reg == RADIX_HEX) && !seen_exponent_reg)
                begin
                    take_dig = 1'b1;
                end
            end
        end

        // digit: exponent digit or mantissa accumulate
        if (take_dig)
        begin
            keep = 1'b1;
            take = 1'b1;
            if (seen_exponent_reg)
            begin
                exp_digit_seen_next = 1'b1;
            end
            else
            begin
                seen_mantissa_next = 1'b1;
                if (!seen_point_reg && !overflow_reg)
                begin
                    if (cand > PROD_W'(MAG_LIMIT))
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        magnitude_next = cand[VALUE_WIDTH-1:0];
                    end
                end
            end
        end

        // bookkeeping for a kept character
        if (keep)
        begin
            if (text_length_reg == 2'd0)
            begin
                leads_with_sign_next = (kept_ch == CH_PLUS) || (kept_ch == CH_MINUS);
            end
            if (text_length_reg != 2'd3)
            begin
                text_length_next = 2'(text_length_reg + 2'd1);
            end
            last_was_zero_next = (kept_ch == CH_ZERO);
            last_was_exp_next  = (kept_ch == CH_LC_E) || (kept_ch == CH_LC_P);
        end

        // token end: report and start a fresh token
        finish = !take;
        if (finish)
        begin
            seen_mantissa_next   = 1'b0;
            seen_exponent_next   = 1'b0;
            seen_sign_next       = 1'b0;
            seen_point_next      = 1'b0;
            exp_digit_seen_next  = 1'b0;
            kinds_left_next      = accepted_kinds_reg;
            kind_read_next       = KIND_BOTH;
            radix_next           = RADIX_DEC;
            text_length_next     = 2'd0;
            leads_with_sign_next = 1'b0;
            negative_next        = 1'b0;
            last_was_zero_next   = 1'b0;
            last_was_exp_next    = 1'b0;
            magnitude_next       = '0;
            overflow_next        = 1'b0;
        end

        res_beat_next.consumed  = take;
        res_beat_next.done_res  = finish;
        res_beat_next.status    = finish ? fin_status : ST_INT_OK;
        res_beat_next.int_value = finish ? fin_value : '0;
    end

    // result valid: set on accept, cleared when taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // token state and valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_mantissa_reg   <= 1'b0;
            seen_exponent_reg   <= 1'b0;
            seen_sign_reg       <= 1'b0;
            seen_point_reg      <= 1'b0;
            exp_digit_seen_reg  <= 1'b0;
            kinds_left_reg      <= KIND_BOTH;
            kind_read_reg       <= KIND_BOTH;
            radix_reg           <= RADIX_DEC;
            text_length_reg     <= 2'd0;
            leads_with_sign_reg <= 1'b0;
            negative_reg        <= 1'b0;
            last_was_zero_reg   <= 1'b0;
            last_was_exp_reg    <= 1'b0;
            magnitude_reg       <= '0;
            overflow_reg        <= 1'b0;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                seen_mantissa_reg   <= seen_mantissa_next;
                seen_exponent_reg   <= seen_exponent_next;
                seen_sign_reg       <= seen_sign_next;
                seen_point_reg      <= seen_point_next;
                exp_digit_seen_reg  <= exp_digit_seen_next;
                kinds_left_reg      <= kinds_left_next;
                kind_read_reg       <= kind_read_next;
                radix_reg           <= radix_next;
                text_length_reg     <= text_length_next;
                leads_with_sign_reg <= leads_with_sign_next;
                negative_reg        <= negative_next;
                last_was_zero_reg   <= last_was_zero_next;
                last_was_exp_reg    <= last_was_exp_next;
                magnitude_reg       <= magnitude_next;
                overflow_reg        <= overflow_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_beat_reg <= res_beat_next;
        end
    end

endmodule

FILE: sv/nls_checker.sv
// Port-level checker for numeric_literal_scanner, bound to the top level.
// Depends on nls_pkg for the beat types and status codes.
module nls_port_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [nls_pkg::APB_ADDR_W-1:0] paddr,
    input logic [nls_pkg::APB_DATA_W-1:0] pwdata,
    input logic [nls_pkg::APB_DATA_W-1:0] prdata,
    input logic                           pready,
    input logic                           char_valid,
    input logic                           char_ready,
    input nls_pkg::char_beat_t            char_beat,
    input logic                           res_valid,
    input logic                           res_ready,
    input nls_pkg::res_beat_t             res_beat
);
    import nls_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_beat))
    else $error("result beat changed while stalled");

    // every accepted character gives a result beat the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_ready |=> res_valid)
    else $error("accepted character produced no result");

    // end of stream always closes the token
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_ready && char_beat.at_end |=> res_beat.done_res)
    else $error("end of stream did not end the token");

    // token end never consumes; a consumed character reports nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_beat.consumed != res_beat.done_res) &&
                      (res_beat.done_res ||
                       ((res_beat.status == ST_INT_OK) && (res_beat.int_value == '0))))
    else $error("consumed and done_res inconsistent");

    // only an integer result carries a value
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_beat.status != ST_INT_OK) |-> res_beat.int_value == '0)
    else $error("value present with non-integer status");

endmodule

bind numeric_literal_scanner nls_port_checker u_nls_port_checker (.*);
